>>> hw/rtl/sobel_pkg.sv
// Shared types and constants of the Sobel edge magnitude core.
// Used by the stream interface and the top level; depends on nothing.
package sobel_pkg;

	localparam int PIX_W      = 8;
	localparam int DIM_W      = 10;
	localparam int POS_W      = 9;
	localparam int MAX_HEIGHT = 512;
	localparam int DIM_MIN    = 3;
	localparam int EDGE_LIMIT = 128;
	localparam int EDGE_SAT   = 255;
	localparam int GRAD_W     = 10;
	localparam int SUM_W      = 11;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd320;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd240;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] edge_value;
		logic [POS_W-1:0] out_col;
		logic [POS_W-1:0] out_row;
		logic             frame_last;
	} result_t;

endpackage

>>> hw/rtl/sobel_stream_if.sv
// Valid/ready stream channel carrying one payload of type T per transaction.
// Depends on sobel_pkg for the default payload type.
interface sobel_stream_if #(
	parameter type T = sobel_pkg::pixel_t
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/sobel_edge_magnitude_core.sv
// Top level of the streaming 3x3 Sobel edge magnitude core.
// Depends on sobel_pkg, sobel_stream_if and sobel_ram.
//
// Usage:
//   pixels carries an 8-bit greyscale frame in raster order, one pixel per
//   transaction. edges carries one result per interior pixel: the clipped
//   gradient magnitude, its centre column and row, and a last-of-frame mark.
//   Border pixels give no result. The result for centre (c-1, r-1) follows
//   the pixel at (c, r).
//   After the pixel that completes its window is accepted, the line stores
//   are read into the read stage, then the single-pass gradient goes into
//   the output register. Throughput: one pixel per cycle, sustained while
//   edges does not hold off results; set by the one read and one write port
//   of each line store.
//   Configuration: image_width (index 0) and image_height (index 1) through
//   cfg_wen/cfg_index/cfg_data; either write restarts the frame at pixel 0.
//   Write only while no transaction is in flight.
//   Reset: frame 320x240, position 0, window cleared; line stores hold
//   garbage until written, which never reaches a result.
//   Stall: a result waits in the output register; a pixel is still taken
//   while the read stage is empty, otherwise pixels is held off.
module sobel_edge_magnitude_core #(
	parameter int MAX_WIDTH = 512
) (
	input  logic                               clk,
	input  logic                               arst_n,
	sobel_stream_if.sink                       pixels,
	sobel_stream_if.source                     edges,
	input  logic                               cfg_wen,
	input  logic [0:0]                         cfg_index,
	input  logic [sobel_pkg::DIM_W-1:0]        cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WB = (CW + 1 > sobel_pkg::DIM_W) ? CW + 1 : sobel_pkg::DIM_W;
	localparam int PW = sobel_pkg::PIX_W;
	localparam int HW = sobel_pkg::POS_W;

	logic [sobel_pkg::DIM_W-1:0] width_q;
	logic [sobel_pkg::DIM_W-1:0] height_q;
	logic [CW-1:0]               col_q;
	logic [HW-1:0]               row_q;

	logic [WB-1:0]               w_ext;
	logic [WB-1:0]               w_eff;
	logic [CW-1:0]               col_last;
	logic [sobel_pkg::DIM_W-1:0] h_eff;
	logic [HW-1:0]               row_last;

	logic                        accept;
	logic                        advance;
	logic                        emit;

	logic                        valid_s1;
	logic                        emit_s1;
	logic                        last_s1;
	logic [PW-1:0]               px_s1;
	logic [CW-1:0]               col_s1;
	logic [HW-1:0]               row_s1;

	logic [PW-1:0]               up_rd;
	logic [PW-1:0]               mid_rd;
	logic [PW-1:0]               win_q [3][2];

	logic                        valid_s2;
	sobel_pkg::result_t          res_s2;
	logic [sobel_pkg::SUM_W-1:0] grad_sum;
	logic [PW-1:0]               edge_val;

	function automatic logic [sobel_pkg::GRAD_W-1:0] abs_diff(
		input logic [sobel_pkg::GRAD_W-1:0] a,
		input logic [sobel_pkg::GRAD_W-1:0] b
	);
		return (a >= b) ? a - b : b - a;
	endfunction

	// effective frame size
	always_comb begin
		w_ext = WB'(width_q);
		if (w_ext < WB'(sobel_pkg::DIM_MIN)) begin
			w_eff = WB'(sobel_pkg::DIM_MIN);
		end else if (w_ext > WB'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		col_last = CW'(w_eff - WB'(1));

		if (height_q < sobel_pkg::DIM_W'(sobel_pkg::DIM_MIN)) begin
			h_eff = sobel_pkg::DIM_W'(sobel_pkg::DIM_MIN);
		end else if (height_q > sobel_pkg::DIM_W'(sobel_pkg::MAX_HEIGHT)) begin
			h_eff = sobel_pkg::DIM_W'(sobel_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		row_last = HW'(h_eff - sobel_pkg::DIM_W'(1));
	end

	assign advance      = !valid_s2 || edges.ready;
	assign pixels.ready = !valid_s1 || advance;
	assign accept       = pixels.valid && pixels.ready;
	assign emit         = (col_q >= CW'(2)) && (row_q >= HW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sobel_pkg::WIDTH_RESET;
			height_q <= sobel_pkg::HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				sobel_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				sobel_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == col_last) begin
				col_q <= '0;
				row_q <= (row_q == row_last) ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixels.data.pixel;
			col_s1  <= col_q;
			row_s1  <= row_q;
			emit_s1 <= emit;
			last_s1 <= (col_q == col_last) && (row_q == row_last);
		end
	end

	sobel_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_upper (
		.clk   (clk),
		.we    (valid_s1 && advance),
		.waddr (col_s1),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (up_rd)
	);

	sobel_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_middle (
		.clk   (clk),
		.we    (valid_s1 && advance),
		.waddr (col_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	// gradient on the shifted window: left column win_q[*][0], centre win_q[*][1], right new
	always_comb begin
		logic [sobel_pkg::GRAD_W-1:0] gx_pos;
		logic [sobel_pkg::GRAD_W-1:0] gx_neg;
		logic [sobel_pkg::GRAD_W-1:0] gy_pos;
		logic [sobel_pkg::GRAD_W-1:0] gy_neg;
		gx_pos = sobel_pkg::GRAD_W'(up_rd) + {1'b0, mid_rd, 1'b0}
			+ sobel_pkg::GRAD_W'(px_s1);
		gx_neg = sobel_pkg::GRAD_W'(win_q[0][0]) + {1'b0, win_q[1][0], 1'b0}
			+ sobel_pkg::GRAD_W'(win_q[2][0]);
		gy_pos = sobel_pkg::GRAD_W'(win_q[2][0]) + {1'b0, win_q[2][1], 1'b0}
			+ sobel_pkg::GRAD_W'(px_s1);
		gy_neg = sobel_pkg::GRAD_W'(win_q[0][0]) + {1'b0, win_q[0][1], 1'b0}
			+ sobel_pkg::GRAD_W'(up_rd);
		grad_sum = sobel_pkg::SUM_W'(abs_diff(gx_pos, gx_neg))
			+ sobel_pkg::SUM_W'(abs_diff(gy_pos, gy_neg));
		edge_val = (grad_sum > sobel_pkg::SUM_W'(sobel_pkg::EDGE_LIMIT))
			? PW'(sobel_pkg::EDGE_SAT) : PW'(grad_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= '0;
				win_q[i][1] <= '0;
			end
		end else if (valid_s1 && advance) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
			end
			win_q[0][1] <= up_rd;
			win_q[1][1] <= mid_rd;
			win_q[2][1] <= px_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit_s1) begin
			res_s2.edge_value <= edge_val;
			res_s2.out_col    <= HW'(col_s1 - CW'(1));
			res_s2.out_row    <= row_s1 - HW'(1);
			res_s2.frame_last <= last_s1;
		end
	end

	assign edges.valid = valid_s2;
	assign edges.data  = res_s2;

endmodule

>>> hw/rtl/sobel_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the line stores of the Sobel core.
module sobel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> dv/sobel_edge_magnitude_checker.sv
// Passive checker for the Sobel edge magnitude core: watches the pixel, edge and register ports,
// predicts each edge result from its own line stores and window, and compares in order.
// Depends on sobel_pkg and sobel_stream_if.
module sobel_edge_magnitude_checker #(
	parameter int MAX_WIDTH = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sobel_stream_if                     pixels,
	sobel_stream_if                     edges,
	input  logic                        cfg_wen,
	input  logic [0:0]                  cfg_index,
	input  logic [sobel_pkg::DIM_W-1:0] cfg_data,
	output int                          mismatches,
	output int                          outstanding,
	output int                          results_checked,
	output int                          frame_ends
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [sobel_pkg::PIX_W-1:0] upper_line [MAX_WIDTH];
	logic [sobel_pkg::PIX_W-1:0] middle_line [MAX_WIDTH];
	logic [sobel_pkg::PIX_W-1:0] win [3][3];
	logic [sobel_pkg::DIM_W-1:0] width_reg;
	logic [sobel_pkg::DIM_W-1:0] height_reg;
	int                          col_pos;
	int                          row_pos;
	int                          fail_count;
	int                          checked_count;
	int                          last_count;
	sobel_pkg::result_t          pending_edges [$];

	function automatic int clamp_dim(input int raw, input int hi);
		if (raw < sobel_pkg::DIM_MIN)
			return sobel_pkg::DIM_MIN;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	task automatic predict_edge(input logic [sobel_pkg::PIX_W-1:0] px, output bit hit,
		output sobel_pkg::result_t res);
		int w;
		int h;
		int c;
		int r;
		int gx;
		int gy;
		int g;
		w = clamp_dim(int'(width_reg), MAX_WIDTH);
		h = clamp_dim(int'(height_reg), sobel_pkg::MAX_HEIGHT);
		c = (col_pos >= w) ? 0 : col_pos;
		r = (row_pos >= h) ? 0 : row_pos;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = upper_line[c];
		win[1][2] = middle_line[c];
		win[2][2] = px;
		upper_line[c] = middle_line[c];
		middle_line[c] = px;
		hit = (r >= 2 && c >= 2);
		res = '0;
		if (hit) begin
			gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
				- (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
			gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
				- (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
			g = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
			res.edge_value = (g > sobel_pkg::EDGE_LIMIT)
				? sobel_pkg::PIX_W'(sobel_pkg::EDGE_SAT) : sobel_pkg::PIX_W'(g);
			res.out_col    = sobel_pkg::POS_W'(c - 1);
			res.out_row    = sobel_pkg::POS_W'(r - 1);
			res.frame_last = (c == w - 1 && r == h - 1);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit                 hit;
		sobel_pkg::result_t want;
		sobel_pkg::result_t got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win[i][j] = '0;
			width_reg     = sobel_pkg::WIDTH_RESET;
			height_reg    = sobel_pkg::HEIGHT_RESET;
			col_pos       = 0;
			row_pos       = 0;
			fail_count    = 0;
			checked_count = 0;
			last_count    = 0;
			pending_edges.delete();
		end else begin
			if (cfg_wen) begin
				case (sobel_pkg::cfg_reg_t'(cfg_index))
					sobel_pkg::REG_IMAGE_WIDTH:  width_reg = cfg_data;
					sobel_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
				col_pos = 0;
				row_pos = 0;
			end
			if (edges.valid && edges.ready) begin
				got = edges.data;
				if (pending_edges.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected edge result value %0d col %0d row %0d last %0b",
							$time, got.edge_value, got.out_col, got.out_row, got.frame_last);
				end else begin
					want = pending_edges.pop_front();
					checked_count++;
					if (want.frame_last)
						last_count++;
					if (got.edge_value !== want.edge_value || got.out_col !== want.out_col
						|| got.out_row !== want.out_row || got.frame_last !== want.frame_last) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: edge result mismatch: expected value %0d col %0d row %0d ",
								"last %0b, got value %0d col %0d row %0d last %0b"}, $time,
								want.edge_value, want.out_col, want.out_row, want.frame_last,
								got.edge_value, got.out_col, got.out_row, got.frame_last);
					end
				end
			end
			if (pixels.valid && pixels.ready) begin
				predict_edge(pixels.data.pixel, hit, want);
				if (hit)
					pending_edges.push_back(want);
			end
		end
		mismatches      <= fail_count;
		outstanding     <= pending_edges.size();
		results_checked <= checked_count;
		frame_ends      <= last_count;
	end
endmodule

>>> dv/sobel_edge_magnitude_core_test.sv
// Top of the Sobel edge magnitude core testbench: clock, reset, pixel and register stimulus,
// random back-pressure on the edge channel, watchdog and verdict.
// Depends on sobel_pkg, sobel_stream_if, the core and sobel_edge_magnitude_checker.
module sobel_edge_magnitude_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WIDTH     = 512;
	localparam int RANDOM_PIXELS = 1950;
	localparam int DRAIN_CYCLES  = 6;
	localparam int IDLE_LIMIT    = 2000;

	typedef enum int {
		STYLE_NOISE,
		STYLE_FLAT,
		STYLE_RAMP,
		STYLE_BINARY
	} pattern_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_wen;
	logic [0:0]                  cfg_index;
	logic [sobel_pkg::DIM_W-1:0] cfg_data;
	logic                        quiet = 1'b0;
	int                          mismatches;
	int                          outstanding;
	int                          results_checked;
	int                          frame_ends;
	int                          pixels_sent = 0;
	int                          settings_used = 0;
	int                          idle_cycles = 0;

	sobel_stream_if #(.T(sobel_pkg::pixel_t))  pixels_if ();
	sobel_stream_if #(.T(sobel_pkg::result_t)) edges_if ();

	always #5 clk = ~clk;

	sobel_edge_magnitude_core #(.MAX_WIDTH(MAX_WIDTH)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels_if),
		.edges     (edges_if),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sobel_edge_magnitude_checker #(.MAX_WIDTH(MAX_WIDTH)) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.pixels          (pixels_if),
		.edges           (edges_if),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.frame_ends      (frame_ends)
	);

	task automatic send_pixel(input logic [sobel_pkg::PIX_W-1:0] px);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			pixels_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixels_if.valid      <= 1'b1;
		pixels_if.data.pixel <= px;
		do @(posedge clk); while (!(pixels_if.valid && pixels_if.ready));
		pixels_sent++;
	endtask

	task automatic settle(input int extra);
		pixels_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_register(input sobel_pkg::cfg_reg_t idx,
		input logic [sobel_pkg::DIM_W-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic reconfigure(input logic [sobel_pkg::DIM_W-1:0] w_raw,
		input logic [sobel_pkg::DIM_W-1:0] h_raw);
		settle(DRAIN_CYCLES);
		if ($urandom_range(0, 1)) begin
			write_register(sobel_pkg::REG_IMAGE_WIDTH, w_raw);
			write_register(sobel_pkg::REG_IMAGE_HEIGHT, h_raw);
		end else begin
			write_register(sobel_pkg::REG_IMAGE_HEIGHT, h_raw);
			write_register(sobel_pkg::REG_IMAGE_WIDTH, w_raw);
		end
		cfg_wen <= 1'b0;
		settings_used++;
	endtask

	task automatic stream_pixels(input int count, input int w, input pattern_t style);
		int base;
		int slope_x;
		int slope_y;
		int pause_at;
		int value;
		base     = $urandom_range(0, 255);
		slope_x  = $urandom_range(0, 24);
		slope_y  = $urandom_range(0, 24);
		pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, count - 1) : -1;
		for (int k = 0; k < count; k++) begin
			case (style)
				STYLE_FLAT: begin
					value = base + $urandom_range(0, 12);
					if (value > 255)
						value = 255;
				end
				STYLE_RAMP:   value = (base + (k % w) * slope_x + (k / w) * slope_y) % 256;
				STYLE_BINARY: value = $urandom_range(0, 1) ? 255 : 0;
				default:      value = $urandom_range(0, 255);
			endcase
			if (k == pause_at)
				settle(0);
			send_pixel(sobel_pkg::PIX_W'(value));
		end
	endtask

	initial begin
		edges_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			int stall;
			stall = quiet ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				edges_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			edges_if.ready <= 1'b1;
			do @(posedge clk); while (!(edges_if.valid && edges_if.ready));
		end
	end

	always @(posedge clk) begin
		if ((pixels_if.valid && pixels_if.ready) || (edges_if.valid && edges_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [sobel_pkg::PIX_W-1:0] step_frame [9];
		logic [sobel_pkg::PIX_W-1:0] limit_frame [9];
		int random_start;
		int w_raw;
		int h_raw;
		int w;
		int h;
		int count;
		step_frame  = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
			8'd255, 8'd255, 8'd255};
		limit_frame = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
			8'd32, 8'd32, 8'd32};
		pixels_if.valid <= 1'b0;
		pixels_if.data  <= '0;
		cfg_wen         <= 1'b0;
		cfg_index       <= sobel_pkg::REG_IMAGE_WIDTH;
		cfg_data        <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame size: first row only, nothing comes out
		for (int k = 0; k < 5; k++)
			send_pixel((k % 2) ? 8'd255 : 8'd0);
		// undersized registers clamp to 3x3; two frames back to back
		reconfigure(10'd0, 10'd2);
		foreach (step_frame[k])
			send_pixel(step_frame[k]);
		foreach (limit_frame[k])
			send_pixel(limit_frame[k]);

		random_start = pixels_sent;
		reconfigure(10'd512, 10'd3);
		stream_pixels(2 * 512 + 40, 512, pattern_t'($urandom_range(0, 3)));
		reconfigure(10'd3, 10'd1023);
		stream_pixels(3 * 60, 3, pattern_t'($urandom_range(0, 3)));
		reconfigure(10'd1023, 10'd0);
		stream_pixels(20, 512, STYLE_NOISE);
		while (pixels_sent - random_start < RANDOM_PIXELS) begin
			w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
			h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			w     = (w_raw < sobel_pkg::DIM_MIN) ? sobel_pkg::DIM_MIN : w_raw;
			h     = (h_raw < sobel_pkg::DIM_MIN) ? sobel_pkg::DIM_MIN : h_raw;
			count = $urandom_range(1, 2) * w * h;
			if ($urandom_range(0, 3) == 0)
				count -= $urandom_range(1, w * h - 1);
			reconfigure(sobel_pkg::DIM_W'(w_raw), sobel_pkg::DIM_W'(h_raw));
			quiet = ($urandom_range(0, 4) == 0);
			stream_pixels(count, w, pattern_t'($urandom_range(0, 3)));
		end

		settle(DRAIN_CYCLES);
		$display({"Run covered %0d pixels over %0d frame-size settings ",
			"(clamped and extreme sizes too)"}, pixels_sent, settings_used);
		$display("%0d edge results compared, %0d frame ends, %0d mismatches, %0d still awaited",
			results_checked, frame_ends, mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
